### src/pfpa_pkg.sv
package pfpa_pkg;
   localparam int FRAME_BYTES = 262144;
   localparam int PALETTE_DEPTH = 256;
   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int PAL_W = $clog2(PALETTE_DEPTH);
   localparam int PCNT_W = PAL_W + 1;
   localparam logic [14:0] MAX_DIM = 15'd30000;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] DC_1 = 3'd0;
   localparam logic [2:0] DC_4 = 3'd1;
   localparam logic [2:0] DC_8 = 3'd2;
   localparam logic [2:0] DC_16 = 3'd3;
   localparam logic [2:0] DC_24 = 3'd4;
   localparam logic [2:0] DC_32 = 3'd5;

   localparam logic [1:0] REG_DEPTH = 2'd0;
   localparam logic [1:0] REG_WIDTH = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_CHECK, S_SEARCH, S_SWAIT, S_PRD, S_PRWAIT,
      S_BRD, S_BWAIT, S_BWR, S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture item and start address math
      logic addr_step;  // advance address pipeline
      logic srch_start;
      logic srch_rd;    // issue palette read at search index
      logic srch_next;
      logic pal_append; // write new entry
      logic pal_rd;     // read palette at stored index
      logic byte_wr;    // write frame byte
      logic byte_next;
      logic clr_wr;
      logic set_status;
      logic [1:0] status;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_bad;
      logic mode;
      logic palette_kind;
      logic srch_done;   // index reached palette_used
      logic srch_hit;
      logic can_append;
      logic last_byte;
      logic clr_done;
   } sts_type;
endpackage

### src/pfpa_ram.sv
module pfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // single write, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

### src/pfpa_ctrl.sv
module pfpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  pfpa_pkg::sts_type sts,
   output pfpa_pkg::cmd_type cmd
);
   import pfpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (sts.clr_done) state_in = S_IDLE;
         S_IDLE: if (req_tvalid) state_in = S_ADDR;
         S_ADDR: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.range_bad) state_in = S_DONE;
            else if (sts.palette_kind && sts.mode) state_in = S_SEARCH;
            else if (sts.palette_kind) state_in = S_BRD;
            else state_in = S_BRD;
         end
         S_SEARCH: begin
            if (sts.srch_done) begin
               state_in = sts.can_append ? S_BRD : S_DONE;
            end else begin
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: state_in = S_PRWAIT;
         S_PRWAIT: state_in = sts.srch_hit ? S_BRD : S_SEARCH;
         S_PRD: state_in = S_DONE;
         S_BRD: state_in = S_BWAIT;
         S_BWAIT: state_in = S_BWR;
         S_BWR: begin
            if (sts.palette_kind && !sts.mode) state_in = S_PRD;
            else if (sts.last_byte) state_in = S_DONE;
            else state_in = S_BRD;
         end
         S_DONE: if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.status = ST_OK;
      case (state_ff)
         S_CLEAR: cmd.clr_wr = 1'b1;
         S_IDLE: cmd.load = req_tvalid;
         S_ADDR: cmd.addr_step = 1'b1;
         S_CHECK: begin
            cmd.srch_start = 1'b1;
            if (sts.range_bad) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_RANGE;
            end
         end
         S_SEARCH: begin
            if (sts.srch_done) begin
               if (sts.can_append) begin
                  cmd.pal_append = 1'b1;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_FULL;
               end
            end else begin
               cmd.srch_rd = 1'b1;
            end
         end
         S_PRWAIT: cmd.srch_next = !sts.srch_hit;
         S_BWR: begin
            cmd.byte_wr = sts.mode;
            cmd.byte_next = 1'b1;
            cmd.pal_rd = sts.palette_kind && !sts.mode;
         end
         S_DONE: cmd.rsp_load = !rsp_valid_ff || rsp_tready;
         default: cmd = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp_tvalid = rsp_valid_ff;
endmodule

### src/pfpa_dp.sv
module pfpa_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_wdata,
   input  logic [55:0]       req_tdata,
   input  pfpa_pkg::cmd_type cmd,
   output pfpa_pkg::sts_type sts,
   output logic [31:0]       rsp_tdata
);
   import pfpa_pkg::*;

   logic [2:0]  depth_ff;
   logic [14:0] width_ff, height_ff;
   logic        mode_ff;
   logic [14:0] x_ff, y_ff;
   logic [23:0] key_ff;
   logic [5:0]  bits;
   logic [14:0] w_sat, h_sat;
   logic [20:0] col_ff;
   logic [17:0] stride_ff;
   logic [33:0] base_ff;
   logic [34:0] end_addr;
   logic [34:0] addr_ff;
   logic [1:0]  nbytes, bidx_ff;
   logic [PCNT_W-1:0] used_ff, sidx_ff, cap, idx_ff;
   logic [23:0] pal_rd;
   logic [7:0]  fb_rd;
   logic [7:0]  lo_ff, hi_ff, top_ff;
   logic [7:0]  ro_ff, go_ff, bo_ff;
   logic [1:0]  status_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic        clr_done_ff;
   logic [2:0]  shift;
   logic [7:0]  fmask, wbyte, pidx;
   logic [7:0]  v16_lo, v16_hi;
   logic [PAL_W-1:0] pal_raddr;
   logic [ADDR_W-1:0] fb_addr;
   logic        fb_we;
   logic [7:0]  fb_wdata;
   logic [7:0]  rsp_r, rsp_g, rsp_b;
   logic [4:0]  c5r, c5g, c5b;

   always_comb begin
      case (depth_ff)
         DC_1: bits = 6'd1;
         DC_4: bits = 6'd4;
         DC_8: bits = 6'd8;
         DC_16: bits = 6'd16;
         DC_24: bits = 6'd24;
         DC_32: bits = 6'd32;
         default: bits = 6'd0;
      endcase
   end
   assign nbytes = (depth_ff inside {DC_1, DC_4, DC_8}) ? 2'd1 :
                   (depth_ff == DC_16) ? 2'd2 : 2'd3;
   assign w_sat = (width_ff > MAX_DIM) ? MAX_DIM : width_ff;
   assign h_sat = (height_ff > MAX_DIM) ? MAX_DIM : height_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DC_1;
         width_ff <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEPTH: depth_ff <= csr_wdata[2:0];
            REG_WIDTH: width_ff <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item capture, stride and column
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tdata[0];
         x_ff <= req_tdata[15:1];
         y_ff <= req_tdata[30:16];
         key_ff <= {req_tdata[38:31], req_tdata[46:39], req_tdata[54:47]};
      end
      col_ff <= 21'(x_ff) * 21'(bits);
      stride_ff <= 18'(((21'(w_sat) * 21'(bits) + 21'd31) >> 5) << 2);
      if (cmd.addr_step) begin
         base_ff <= 34'(y_ff) * 34'(stride_ff);
      end
   end

   assign end_addr = 35'(base_ff) + 35'(col_ff >> 3) + 35'(nbytes);

   // range check
   logic range_now;
   assign range_now = (bits == 6'd0) || (x_ff >= w_sat) || (y_ff >= h_sat) ||
                      (end_addr > 35'(FRAME_BYTES));
   assign sts.range_bad = range_now;
   assign sts.mode = mode_ff;
   assign sts.palette_kind = (depth_ff inside {DC_1, DC_4, DC_8});

   // palette search and append
   always_comb begin
      case (depth_ff)
         DC_1: cap = PCNT_W'(2);
         DC_4: cap = (PALETTE_DEPTH < 16) ? PCNT_W'(PALETTE_DEPTH) : PCNT_W'(16);
         default: cap = PCNT_W'(PALETTE_DEPTH);
      endcase
   end
   assign sts.srch_done = (sidx_ff >= used_ff);
   assign sts.can_append = (used_ff < cap);
   assign sts.srch_hit = (pal_rd == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.pal_append) begin
         used_ff <= used_ff + 1'b1;
      end
      if (cmd.srch_start) sidx_ff <= '0;
      else if (cmd.srch_next) sidx_ff <= sidx_ff + 1'b1;
      if (cmd.pal_append) idx_ff <= used_ff;
      else if (cmd.srch_rd) idx_ff <= sidx_ff;
      else if (cmd.pal_rd) idx_ff <= PCNT_W'(pidx);
   end

   // search index on writes, stored index held on reads
   assign pal_raddr = cmd.pal_rd ? PAL_W'(pidx) :
                      mode_ff ? PAL_W'(sidx_ff) : PAL_W'(idx_ff);

   pfpa_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
      .clock  (clock),
      .wr_en  (cmd.pal_append),
      .wr_addr(PAL_W'(used_ff)),
      .wr_data(key_ff),
      .rd_addr(pal_raddr),
      .rd_data(pal_rd)
   );

   // frame byte sequencing
   assign shift = 3'(4'd8 - 4'(col_ff[2:0]) - 4'(bits));
   assign fmask = 8'(((9'd1 << bits) - 9'd1) << shift);
   assign pidx = (fb_rd & fmask) >> shift;
   assign v16_lo = {key_ff[13:11], key_ff[7:3]};
   assign v16_hi = {1'b0, key_ff[23:19], key_ff[15:14]};

   always_comb begin
      if (sts.palette_kind) begin
         wbyte = (fb_rd & ~fmask) | (8'(idx_ff << shift) & fmask);
      end else if (depth_ff == DC_16) begin
         wbyte = (bidx_ff == 2'd0) ? v16_lo : v16_hi;
      end else begin
         case (bidx_ff)
            2'd0: wbyte = key_ff[7:0];
            2'd1: wbyte = key_ff[15:8];
            default: wbyte = key_ff[23:16];
         endcase
      end
   end

   assign sts.last_byte = (bidx_ff == nbytes - 2'd1);
   assign sts.clr_done = clr_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.srch_start) bidx_ff <= '0;
      else if (cmd.byte_next) bidx_ff <= bidx_ff + 2'd1;
      if (cmd.byte_next) begin
         if (bidx_ff == 2'd0) lo_ff <= fb_rd;
         if (bidx_ff == 2'd1) hi_ff <= fb_rd;
         if (bidx_ff == 2'd2) top_ff <= fb_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(FRAME_BYTES - 1)) clr_done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) addr_ff <= 35'(base_ff) + 35'(col_ff >> 3) + 35'(bidx_ff);

   assign fb_we = cmd.clr_wr | cmd.byte_wr;
   assign fb_wdata = cmd.clr_wr ? 8'd0 : wbyte;
   assign fb_addr = cmd.clr_wr ? clr_ff : ADDR_W'(addr_ff);

   pfpa_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_fb (
      .clock  (clock),
      .wr_en  (fb_we),
      .wr_addr(fb_addr),
      .wr_data(fb_wdata),
      .rd_addr(ADDR_W'(addr_ff)),
      .rd_data(fb_rd)
   );

   // result assembly
   always_ff @(posedge clock) begin
      if (cmd.set_status) status_ff <= cmd.status;
      else if (cmd.srch_start) status_ff <= ST_OK;
   end

   assign c5b = lo_ff[4:0];
   assign c5g = {hi_ff[1:0], lo_ff[7:5]};
   assign c5r = hi_ff[6:2];

   always_comb begin
      rsp_r = '0;
      rsp_g = '0;
      rsp_b = '0;
      if (!mode_ff && status_ff == ST_OK) begin
         if (sts.palette_kind) begin
            if (idx_ff < used_ff) begin
               rsp_r = pal_rd[23:16];
               rsp_g = pal_rd[15:8];
               rsp_b = pal_rd[7:0];
            end
         end else if (depth_ff == DC_16) begin
            rsp_r = (c5r == 5'b11111) ? 8'd255 : {c5r, 3'b000};
            rsp_g = (c5g == 5'b11111) ? 8'd255 : {c5g, 3'b000};
            rsp_b = (c5b == 5'b11111) ? 8'd255 : {c5b, 3'b000};
         end else begin
            rsp_b = lo_ff;
            rsp_g = hi_ff;
            rsp_r = top_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         ro_ff <= rsp_r;
         go_ff <= rsp_g;
         bo_ff <= rsp_b;
      end
   end
   logic [1:0] st_out_ff;
   always_ff @(posedge clock) if (cmd.rsp_load) st_out_ff <= status_ff;

   assign rsp_tdata = {6'd0, st_out_ff, bo_ff, go_ff, ro_ff};
endmodule

### src/palette_framebuffer_pixel_access.sv
// sequence: address setup, range check; a rejected item then goes to the result, a
// direct-colour item visits its frame bytes in turn, a palette read reads its frame byte
// then the palette entry, and a palette write searches the palette RAM before its byte write
// throughput: one item at a time; the next item is taken the cycle after the result is
// registered, later while the previous result is still waiting in the output register
// reset: synchronous, active high; afterwards a clearing pass writes zero to every frame
// byte, during which no item is accepted
module palette_framebuffer_pixel_access (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode, x_pos, y_pos, red_in, green_in, blue_in
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red_out, green_out, blue_out, status
   output logic [31:0] rsp_tdata
);
   import pfpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pfpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   pfpa_dp u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_tdata(req_tdata), .cmd(cmd), .sts(sts),
      .rsp_tdata(rsp_tdata)
   );
endmodule
